>>> rtl/qfo_pkg.sv
// ----------------------------------------------------------------------------
// qfo_pkg: shared types and constants for the quadratic fade-out PCM packer
// Holds the sequencer states, the configuration register indexes, the fixed
// PCM limits and gain constants, and the control struct that drives a lane.
// ----------------------------------------------------------------------------
package qfo_pkg;

  // Sample and gain widths fixed by the stream format.
  localparam int SampleW   = 32;
  localparam int PcmW      = 24;
  localparam int CountW    = 32;
  localparam int GainShift = 16;
  localparam int GainW     = GainShift + 1;          // 0 .. 1.0 in Q16
  localparam int ProdW     = SampleW + GainW;        // signed product width
  localparam int SqW       = 2 * GainW;              // square of the quotient
  localparam int DivSteps  = GainShift;              // one quotient bit a step
  localparam int DivCntW   = 5;
  localparam int CfgIdxW   = 2;

  localparam logic [GainW-1:0]      GainOne = GainW'(1) << GainShift;
  localparam logic signed [PcmW-1:0] PcmMin = 24'sh800000;
  localparam logic signed [PcmW-1:0] PcmMax = 24'sh7FFFFF;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgTotalFrames = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFadeLength  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDepth24     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_SQR,
    ST_GAIN,
    ST_MUL,
    ST_PACK
  } qfo_state_t;

  // Control shared by both sample lanes.
  typedef struct packed {
    logic mul_en;     // capture sample * gain
    logic depth_24;   // 1: 24-bit output, 0: 16-bit output
  } qfo_lane_ctl_t;

endpackage

>>> rtl/qfo_div.sv
// ----------------------------------------------------------------------------
// qfo_div: serial divider for the fade ratio
// Computes (remaining << 16) / fade one quotient bit a cycle. The caller must
// keep remaining <= fade for the quotient to fit in 17 bits; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module qfo_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [qfo_pkg::CountW-1:0]       remaining,
  input  logic [qfo_pkg::CountW-1:0]       divisor,
  output logic                             done,
  output logic [qfo_pkg::GainW-1:0]        quotient
);

  logic                            busy_r,  busy_nxt;
  logic                            done_r,  done_nxt;
  logic [qfo_pkg::DivCntW-1:0]     cnt_r,   cnt_nxt;
  logic [qfo_pkg::CountW-1:0]      rem_r,   rem_nxt;
  logic [qfo_pkg::CountW-1:0]      dvs_r,   dvs_nxt;
  logic [qfo_pkg::GainW-1:0]       quo_r,   quo_nxt;
  logic [qfo_pkg::CountW:0]        shifted;
  logic                            fits;

  assign shifted = {rem_r, 1'b0};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      // With remaining <= fade, the integer part of remaining / fade is 0 or 1.
      busy_nxt = 1'b1;
      dvs_nxt  = divisor;
      cnt_nxt  = qfo_pkg::DivCntW'(qfo_pkg::DivSteps);
      if (remaining >= divisor) begin
        rem_nxt = remaining - divisor;
        quo_nxt = qfo_pkg::GainW'(1);
      end else begin
        rem_nxt = remaining;
        quo_nxt = '0;
      end
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = qfo_pkg::CountW'(shifted - {1'b0, dvs_r});
      end else begin
        rem_nxt = shifted[qfo_pkg::CountW-1:0];
      end
      quo_nxt = {quo_r[qfo_pkg::GainW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == qfo_pkg::DivCntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/qfo_lane.sv
// ----------------------------------------------------------------------------
// qfo_lane: one channel of the fade and PCM conversion
// Multiplies the sample by the Q16 gain into a register, then floors by 2^16,
// clamps to signed 24 bits and, in 16-bit mode, keeps the top 16 bits.
// ----------------------------------------------------------------------------
module qfo_lane (
  input  logic                                clk,
  input  qfo_pkg::qfo_lane_ctl_t              ctl,
  input  logic signed [qfo_pkg::SampleW-1:0]  sample,
  input  logic [qfo_pkg::GainW-1:0]           gain,
  output logic signed [qfo_pkg::PcmW-1:0]     pcm
);

  logic signed [qfo_pkg::ProdW-1:0]           prod_full;
  logic signed [qfo_pkg::ProdW-1:0]           prod_r, prod_nxt;
  logic signed [qfo_pkg::ProdW-qfo_pkg::GainShift-1:0] scaled;
  logic signed [qfo_pkg::PcmW-1:0]            clamped;

  // The gain is at most 2^16, so the signed product fits in ProdW bits.
  assign prod_full = sample * $signed({1'b0, gain});
  assign prod_nxt  = ctl.mul_en ? prod_full : prod_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Arithmetic shift gives the floor of the Q16 product.
  assign scaled = prod_r[qfo_pkg::ProdW-1:qfo_pkg::GainShift];

  always_comb begin
    if (scaled > qfo_pkg::PcmMax) begin
      clamped = qfo_pkg::PcmMax;
    end else if (scaled < qfo_pkg::PcmMin) begin
      clamped = qfo_pkg::PcmMin;
    end else begin
      clamped = scaled[qfo_pkg::PcmW-1:0];
    end
    if (ctl.depth_24) begin
      pcm = clamped;
    end else begin
      pcm = {{8{clamped[qfo_pkg::PcmW-1]}}, clamped[qfo_pkg::PcmW-1:8]};
    end
  end

endmodule

>>> rtl/quadratic_fade_out_and_pcm_pack_core.sv
// ----------------------------------------------------------------------------
// quadratic_fade_out_and_pcm_pack_core: stereo fade-out and PCM conversion
// Counts emitted frames, applies a quadratic gain over the final fade and
// converts both channels to clamped 24-bit or 16-bit PCM.
// ----------------------------------------------------------------------------
// Each accepted word is one stereo frame of signed 32-bit samples, and each
// frame gives exactly one output word. The block works on one frame at a
// time; each frame passes through the 16-step serial divider that forms
// the fade ratio and the square, gain and multiply stages around it. The
// output word sits in its own register, so the next frame is taken
// while a finished word still waits for out_ready. The frames still to come,
// counting the current one, are total_frames minus the frames already emitted
// (never below zero). When fade_length is nonzero and that figure is at most
// fade_length, both channels are scaled by the square of remaining/fade_length
// in Q16, floored, then clamped to signed 24 bits; in 16-bit mode the top 16
// bits are kept and sign-extended. out_last_frame marks the final frame. The
// frame counter stops at its top value, and only reset clears it; register
// writes leave it alone. Registers are to be written through cfg_we,
// cfg_index and cfg_wdata only while the block is idle; the block itself
// does not enforce this. An index past the last register is ignored.
// ----------------------------------------------------------------------------
module quadratic_fade_out_and_pcm_pack_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [qfo_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [qfo_pkg::CountW-1:0]         cfg_wdata,
  // input frames
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [qfo_pkg::SampleW-1:0] in_left_in,
  input  logic signed [qfo_pkg::SampleW-1:0] in_right_in,
  // output frames
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [qfo_pkg::PcmW-1:0]    out_left_pcm,
  output logic signed [qfo_pkg::PcmW-1:0]    out_right_pcm,
  output logic                               out_last_frame
);

  // Configuration registers.
  logic [qfo_pkg::CountW-1:0]  total_r, total_nxt;
  logic [qfo_pkg::CountW-1:0]  fade_r,  fade_nxt;
  logic                        depth_r, depth_nxt;

  // Frame bookkeeping.
  logic [qfo_pkg::CountW-1:0]  emitted_r, emitted_nxt;
  logic [qfo_pkg::CountW-1:0]  remaining_r, remaining_nxt;
  logic                        fade_on_r, fade_on_nxt;
  logic signed [qfo_pkg::SampleW-1:0] left_r, left_nxt;
  logic signed [qfo_pkg::SampleW-1:0] right_r, right_nxt;

  // Gain path.
  logic [qfo_pkg::SqW-1:0]     sq_r, sq_nxt;
  logic [qfo_pkg::GainW-1:0]   gain_r, gain_nxt;
  logic [qfo_pkg::SqW-qfo_pkg::GainShift-1:0] sq_shifted;
  logic                        div_done;
  logic [qfo_pkg::GainW-1:0]   quotient;

  // Sequencer.
  qfo_pkg::qfo_state_t         state_r, state_nxt;
  logic                        in_accept;
  logic                        div_start;
  logic                        mul_en;
  logic                        out_load;
  logic                        out_free;
  qfo_pkg::qfo_lane_ctl_t      lane_ctl;

  // Output register.
  logic                        out_valid_r, out_valid_nxt;
  logic signed [qfo_pkg::PcmW-1:0] out_left_r, out_left_nxt;
  logic signed [qfo_pkg::PcmW-1:0] out_right_r, out_right_nxt;
  logic                        out_last_r, out_last_nxt;
  logic signed [qfo_pkg::PcmW-1:0] left_pcm, right_pcm;

  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // Register writes. An index past the last register matches no arm.
  always_comb begin
    total_nxt = total_r;
    fade_nxt  = fade_r;
    depth_nxt = depth_r;
    if (cfg_we) begin
      case (cfg_index)
        qfo_pkg::CfgTotalFrames: total_nxt = cfg_wdata;
        qfo_pkg::CfgFadeLength:  fade_nxt  = cfg_wdata;
        qfo_pkg::CfgDepth24:     depth_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // On acceptance the frames still to come are worked out from the count
  // before it advances; the count then saturates at its top value.
  always_comb begin
    emitted_nxt   = emitted_r;
    remaining_nxt = remaining_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    if (in_accept) begin
      remaining_nxt = (total_r > emitted_r) ? (total_r - emitted_r) : '0;
      left_nxt      = in_left_in;
      right_nxt     = in_right_in;
      if (emitted_r != '1) begin
        emitted_nxt = emitted_r + 1'b1;
      end
    end
  end

  // The fade applies only within the last fade_length frames and past the total.
  assign fade_on_nxt = (state_r == qfo_pkg::ST_PREP)
                       ? ((fade_r != '0) && (remaining_r <= fade_r)) : fade_on_r;

  qfo_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .remaining (remaining_r),
    .divisor   (fade_r),
    .done      (div_done),
    .quotient  (quotient)
  );

  // Square of the Q16 ratio, then back to Q16. Outside the fade the gain is
  // exactly one, so the samples only see the clamp.
  assign sq_nxt     = (state_r == qfo_pkg::ST_SQR) ? quotient * quotient : sq_r;
  assign sq_shifted = sq_r[qfo_pkg::SqW-1:qfo_pkg::GainShift];

  always_comb begin
    gain_nxt = gain_r;
    if (state_r == qfo_pkg::ST_GAIN) begin
      if (!fade_on_r) begin
        gain_nxt = qfo_pkg::GainOne;
      end else if (sq_shifted >= (qfo_pkg::SqW - qfo_pkg::GainShift)'(qfo_pkg::GainOne)) begin
        gain_nxt = qfo_pkg::GainOne;
      end else begin
        gain_nxt = sq_shifted[qfo_pkg::GainW-1:0];
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qfo_pkg::ST_IDLE: if (in_valid) state_nxt = qfo_pkg::ST_PREP;
      qfo_pkg::ST_PREP: state_nxt = qfo_pkg::ST_DIV;
      qfo_pkg::ST_DIV:  if (div_done) state_nxt = qfo_pkg::ST_SQR;
      qfo_pkg::ST_SQR:  state_nxt = qfo_pkg::ST_GAIN;
      qfo_pkg::ST_GAIN: state_nxt = qfo_pkg::ST_MUL;
      qfo_pkg::ST_MUL:  state_nxt = qfo_pkg::ST_PACK;
      qfo_pkg::ST_PACK: if (out_free) state_nxt = qfo_pkg::ST_IDLE;
      default:          state_nxt = qfo_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mul_en    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      qfo_pkg::ST_IDLE: in_ready  = 1'b1;
      qfo_pkg::ST_PREP: div_start = 1'b1;
      qfo_pkg::ST_MUL:  mul_en    = 1'b1;
      qfo_pkg::ST_PACK: out_load  = out_free;
      default: ;
    endcase
  end

  assign lane_ctl.mul_en   = mul_en;
  assign lane_ctl.depth_24 = depth_r;

  qfo_lane u_lane_left (
    .clk    (clk),
    .ctl    (lane_ctl),
    .sample (left_r),
    .gain   (gain_r),
    .pcm    (left_pcm)
  );

  qfo_lane u_lane_right (
    .clk    (clk),
    .ctl    (lane_ctl),
    .sample (right_r),
    .gain   (gain_r),
    .pcm    (right_pcm)
  );

  // Merge both lanes and the last-frame flag into the output word.
  always_comb begin
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_left_nxt  = left_pcm;
      out_right_nxt = right_pcm;
      out_last_nxt  = (remaining_r == qfo_pkg::CountW'(1));
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      fade_r      <= '0;
      depth_r     <= 1'b0;
      emitted_r   <= '0;
      state_r     <= qfo_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      fade_r      <= fade_nxt;
      depth_r     <= depth_nxt;
      emitted_r   <= emitted_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    remaining_r <= remaining_nxt;
    fade_on_r   <= fade_on_nxt;
    left_r      <= left_nxt;
    right_r     <= right_nxt;
    sq_r        <= sq_nxt;
    gain_r      <= gain_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_left_pcm   = out_left_r;
  assign out_right_pcm  = out_right_r;
  assign out_last_frame = out_last_r;

`ifndef SYNTHESIS
  // The frame count advances by one on each accepted frame until it saturates.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (emitted_r != '1) |=> emitted_r == $past(emitted_r) + 1'b1)
    else $error("frame count did not advance on an accepted frame");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == qfo_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  // Within the fade the ratio never exceeds one.
  a_quotient_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_done && fade_on_r |-> quotient <= qfo_pkg::GainOne)
    else $error("fade ratio above one");

  // In 16-bit mode the output word is a sign-extended 16-bit value.
  a_depth16_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !depth_r |->
      (out_left_r[23:15] == '0 || out_left_r[23:15] == '1) &&
      (out_right_r[23:15] == '0 || out_right_r[23:15] == '1))
    else $error("16-bit output outside its range");
`endif

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the quadratic fade-out PCM packer
// Sends stereo frames through the valid/ready input channel, predicts every
// output word from a local model of the frame counter, the Q16 fade gain and
// the PCM clamp, and compares each output word field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

  // An index past the last register. Writes to it must leave every register
  // unchanged.
  localparam logic [qfo_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;

  // A pad used after the expected words have all arrived and before the
  // registers are touched again.
  localparam int LatencyPad = 32;
  localparam int RandomTarget = 1400;
  localparam int TailFrames = 150;
  localparam int CycleLimit = 400000;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic signed [qfo_pkg::PcmW-1:0] left;
    logic signed [qfo_pkg::PcmW-1:0] right;
    logic                            last;
  } pcm_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [qfo_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [qfo_pkg::CountW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [qfo_pkg::SampleW-1:0] in_left_in = '0;
  logic signed [qfo_pkg::SampleW-1:0] in_right_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [qfo_pkg::PcmW-1:0] out_left_pcm;
  logic signed [qfo_pkg::PcmW-1:0] out_right_pcm;
  logic out_last_frame;

  quadratic_fade_out_and_pcm_pack_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_left_pcm  (out_left_pcm),
    .out_right_pcm (out_right_pcm),
    .out_last_frame(out_last_frame)
  );

  always #5 clk = ~clk;

  // Local copies of the registers and of the frame counter. The counter only
  // ever grows (reset is applied once), so every fade is placed relative to
  // its current value. Saturation of the counter at its top value needs
  // 2^32 - 1 frames and so lies outside any run of sensible length.
  logic [qfo_pkg::CountW-1:0] shadow_total = '0;
  logic [qfo_pkg::CountW-1:0] shadow_fade = '0;
  logic                       shadow_depth24 = 1'b0;
  logic [qfo_pkg::CountW-1:0] frames_counted = '0;

  pcm_frame_t pcm_expected[$];

  int unsigned frames_sent = 0;
  int unsigned words_checked = 0;
  int unsigned faded_words = 0;
  int unsigned settings_used = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned stall_cnt = 0;
  bit          idle_on = 1'b0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Q16 gain: the square of remaining/fade, with 1.0 as the ceiling.
  function automatic logic [qfo_pkg::GainW-1:0] fade_gain(
      input logic [qfo_pkg::CountW-1:0] remaining);
    logic [63:0] ratio;
    logic [63:0] squared;
    ratio = ({32'b0, remaining} << qfo_pkg::GainShift) / {32'b0, shadow_fade};
    squared = (ratio * ratio) >> qfo_pkg::GainShift;
    if (squared > 64'(qfo_pkg::GainOne)) squared = 64'(qfo_pkg::GainOne);
    return squared[qfo_pkg::GainW-1:0];
  endfunction

  // Scale by the gain with a flooring shift, clamp to 24 bits, and in 16-bit
  // mode keep the top 16 of those bits, sign-extended.
  function automatic logic signed [qfo_pkg::PcmW-1:0] shape_sample(
      input logic signed [qfo_pkg::SampleW-1:0] s,
      input logic [qfo_pkg::GainW-1:0] gain,
      input logic fading);
    longint v;
    v = s;
    if (fading) v = (v * longint'(gain)) >>> qfo_pkg::GainShift;
    if (v < longint'(qfo_pkg::PcmMin)) v = longint'(qfo_pkg::PcmMin);
    if (v > longint'(qfo_pkg::PcmMax)) v = longint'(qfo_pkg::PcmMax);
    if (!shadow_depth24) v = v >>> 8;
    return v[qfo_pkg::PcmW-1:0];
  endfunction

  function automatic void predict_frame(input logic signed [qfo_pkg::SampleW-1:0] left,
                                        input logic signed [qfo_pkg::SampleW-1:0] right,
                                        output pcm_frame_t want);
    logic [qfo_pkg::CountW-1:0] remaining;
    logic [qfo_pkg::GainW-1:0]  gain;
    logic                       fading;
    remaining = (shadow_total > frames_counted) ? shadow_total - frames_counted : '0;
    fading = (shadow_fade != '0) && (remaining <= shadow_fade);
    gain = fading ? fade_gain(remaining) : qfo_pkg::GainOne;
    want.left = shape_sample(left, gain, fading);
    want.right = shape_sample(right, gain, fading);
    want.last = (remaining == 32'd1);
    if (fading) faded_words++;
    if (frames_counted != '1) frames_counted++;
  endfunction

  // --------------------------------------------------------------------------
  // Shared driving tasks
  // --------------------------------------------------------------------------

  // One register write. The trailing edge keeps the next write enable from
  // landing in the same time step as this one's release.
  task automatic write_reg(input logic [qfo_pkg::CfgIdxW-1:0] idx,
                           input logic [qfo_pkg::CountW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      qfo_pkg::CfgTotalFrames: shadow_total = data;
      qfo_pkg::CfgFadeLength:  shadow_fade = data;
      qfo_pkg::CfgDepth24:     shadow_depth24 = data[0];
      default:                 ;
    endcase
    @(posedge clk);
  endtask

  // Sends one frame. Valid stays high after acceptance; it is only dropped
  // by a gap before the next frame or by the quiet wait, so it is never
  // lowered and raised within one time step.
  task automatic send_frame(input logic [qfo_pkg::SampleW-1:0] left,
                            input logic [qfo_pkg::SampleW-1:0] right);
    pcm_frame_t want;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_left_in <= left;
    in_right_in <= right;
    do @(posedge clk); while (!in_ready);
    predict_frame(left, right, want);
    pcm_expected.push_back(want);
    frames_sent++;
  endtask

  // Stops sending and waits until every predicted word has been seen, then
  // lets the pipeline settle before anything else is written.
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    while (pcm_expected.size() != 0) @(posedge clk);
    repeat (LatencyPad) @(posedge clk);
  endtask

  // Mostly full-range and mid-range values, with the extremes kept frequent.
  function automatic logic [qfo_pkg::SampleW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3, 4: return $urandom;
      9:       return 32'($urandom_range(0, 600)) - 32'd300;
      default: return 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random back-pressure and the in-order compare
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      stall_cnt <= $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pcm_frame_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pcm_expected.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= ReportLimit)
          $display("ERROR: output word with nothing expected: L=%0d R=%0d last=%0b",
                   out_left_pcm, out_right_pcm, out_last_frame);
      end else begin
        want = pcm_expected.pop_front();
        words_checked++;
        if (out_left_pcm !== want.left || out_right_pcm !== want.right ||
            out_last_frame !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= ReportLimit)
            $display("ERROR: word %0d: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                     words_checked, want.left, want.right, want.last,
                     out_left_pcm, out_right_pcm, out_last_frame);
        end
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Registers at their reset values: the total is zero, so every frame lies
  // past the end, and with fading off the samples pass straight through the
  // clamp in 16-bit mode. The last-frame flag must stay low.
  task automatic test_reset_passthrough();
    send_frame(32'h7FFF_FFFF, 32'h8000_0000);
    send_frame(32'h0000_0000, 32'hFFFF_FFFF);
    send_frame(32'h007F_FFFF, 32'hFF80_0000);
    send_frame(32'h0080_0000, 32'hFF7F_FFFF);
    send_frame(32'h0000_00FF, 32'hFFFF_FF01);
    wait_for_quiet();
    settings_used++;
  endtask

  // A four-frame fade in 24-bit mode: one frame before it, the first faded
  // frame at unity gain, the final frame with its flag, then frames past the
  // total where the gain drops to zero.
  task automatic test_fade_edges();
    write_reg(qfo_pkg::CfgDepth24, 32'd1);
    write_reg(qfo_pkg::CfgFadeLength, 32'd4);
    write_reg(qfo_pkg::CfgTotalFrames, frames_counted + 32'd5);
    send_frame(32'h7FFF_FFFF, 32'h8000_0000);
    send_frame(32'h7FFF_FFFF, 32'h8000_0000);
    send_frame(32'h0123_4567, 32'hFEDC_BA98);
    send_frame(32'h8000_0000, 32'h7FFF_FFFF);
    send_frame(32'hFFFF_FFFF, 32'h0000_0001);
    send_frame(32'h7FFF_FFFF, 32'h8000_0000);
    send_frame(32'h0000_0000, 32'h0000_0000);
    wait_for_quiet();
    settings_used++;
  endtask

  // Register extremes. A write to the unused index must change nothing. With
  // total and fade both at their top value the whole run sits inside the
  // fade just below unity gain. A one-frame fade gives unity on the final
  // frame and silence after it.
  task automatic test_register_extremes();
    write_reg(CfgUnused, 32'hFFFF_FFFF);
    write_reg(qfo_pkg::CfgDepth24, 32'd0);
    write_reg(qfo_pkg::CfgTotalFrames, 32'hFFFF_FFFF);
    write_reg(qfo_pkg::CfgFadeLength, 32'hFFFF_FFFF);
    send_frame(32'h7FFF_FFFF, 32'h8000_0000);
    send_frame(32'h0040_0000, 32'hFFC0_0000);
    send_frame(32'h0000_0100, 32'hFFFF_FF00);
    wait_for_quiet();
    settings_used++;
    write_reg(qfo_pkg::CfgFadeLength, 32'd1);
    write_reg(qfo_pkg::CfgTotalFrames, frames_counted + 32'd1);
    write_reg(CfgUnused, 32'h0000_0000);
    send_frame(32'h7FFF_FFFF, 32'h8000_0000);
    send_frame(32'h7FFF_FFFF, 32'h8000_0000);
    wait_for_quiet();
    settings_used++;
  endtask

  // Random settings, each followed by enough frames to run through the fade
  // and usually past its end. Most fades are short so that every gain step is
  // reached; a few use a huge fade length or a random total, which also
  // lands the counter well before or long after the end. Each setting ends
  // with the sender holding off until every word is back.
  task automatic test_random_fades();
    int unsigned fade;
    int unsigned span;
    int unsigned count;
    while (frames_sent < RandomTarget) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0:       fade = 0;
        1:       fade = $urandom;
        default: fade = $urandom_range(1, 48);
      endcase
      span = (fade != 0 && fade <= 48) ? fade : 24;
      write_reg(qfo_pkg::CfgDepth24, 32'($urandom_range(0, 1)));
      write_reg(qfo_pkg::CfgFadeLength, fade);
      if ($urandom_range(0, 5) == 0)
        write_reg(qfo_pkg::CfgTotalFrames, $urandom);
      else
        write_reg(qfo_pkg::CfgTotalFrames,
                  frames_counted + 32'($urandom_range(0, span + 8)));
      count = $urandom_range(span / 2 + 1, span + 12);
      repeat (count) send_frame(pick_sample(), pick_sample());
      wait_for_quiet();
      settings_used++;
    end
  endtask

  // Final stretch at full rate on both sides in 24-bit mode: frames before a
  // long fade, the fade itself, then the frames after it.
  task automatic test_full_rate_tail();
    idle_on = 1'b0;
    write_reg(qfo_pkg::CfgDepth24, 32'd1);
    write_reg(qfo_pkg::CfgFadeLength, 32'd120);
    write_reg(qfo_pkg::CfgTotalFrames, frames_counted + 32'd130);
    repeat (TailFrames) send_frame(pick_sample(), pick_sample());
    wait_for_quiet();
    settings_used++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_passthrough();
    test_fade_edges();
    test_register_extremes();
    test_random_fades();
    test_full_rate_tail();

    $display("Summary: %0d frames sent, %0d words compared, %0d of them inside a fade,",
             frames_sent, words_checked, faded_words);
    $display("         over %0d register settings in both sample depths.", settings_used);
    if (mismatch_cnt == 0 && pcm_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/qfo_pkg.sv
rtl/qfo_div.sv
rtl/qfo_lane.sv
rtl/quadratic_fade_out_and_pcm_pack_core.sv
sim/testbench.sv
